// File: sv/pfa_pkg.sv
// pfa_pkg: shared types and codes of the page frame allocator
// command and status codes, configuration register bundle
// no dependencies
package pfa_pkg;

    localparam int APB_AW = 3;

    localparam logic [1:0] CMD_SEED  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_STACK     = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_TABLE     = 3'd3;
    localparam logic [2:0] ST_UNTRACKED = 3'd4;

    localparam logic [15:0] LOW_FRAME_RST   = 16'd0;
    localparam logic [16:0] FRAME_LIMIT_RST = 17'd57344;

    typedef struct packed {
        logic [15:0] low_frame;
        logic [16:0] frame_limit;
    } t_cfg;

endpackage

// File: sv/pfa_if.sv
// pfa_if: command and result channels of the page frame allocator
// valid/ready handshake, one word per accepted beat
// depends on pfa_pkg
interface pfa_cmd_if
    import pfa_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [15:0]        frame_number;
    logic signed [15:0] owner_id;
    logic [13:0]        entry_index;

    modport source (output valid, command, frame_number, owner_id, entry_index, input ready);
    modport sink   (input valid, command, frame_number, owner_id, entry_index, output ready);
endinterface

interface pfa_res_if
    import pfa_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [15:0]        result_frame;
    logic signed [15:0] result_owner;
    logic [14:0]        tracked_count;

    modport source (output valid, status, result_frame, result_owner, tracked_count, input ready);
    modport sink   (input valid, status, result_frame, result_owner, tracked_count, output ready);
endinterface

// File: sv/pfa_ram.sv
// pfa_ram: simple dual-port synchronous ram, one write and one read port
// read data registered, shown the cycle after the read enable, contents not reset
// depends on pfa_pkg
module pfa_ram
    import pfa_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/pfa_apb_regs.sv
// pfa_apb_regs: apb configuration registers, low frame and frame limit
// register i at byte address 4*i, zero wait states
// depends on pfa_pkg
module pfa_apb_regs
    import pfa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    localparam logic REG_LOW_FRAME   = 1'b0;
    localparam logic REG_FRAME_LIMIT = 1'b1;

    logic [15:0] r_low_frame;
    logic [16:0] r_frame_limit;
    logic        w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_frame   <= LOW_FRAME_RST;
            r_frame_limit <= FRAME_LIMIT_RST;
        end else if (w_wr) begin
            case (paddr[2])
                REG_LOW_FRAME:   r_low_frame   <= pwdata[15:0];
                REG_FRAME_LIMIT: r_frame_limit <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LOW_FRAME:   prdata = {16'd0, r_low_frame};
            REG_FRAME_LIMIT: prdata = {15'd0, r_frame_limit};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg.low_frame   = r_low_frame;
    assign o_cfg.frame_limit = r_frame_limit;

endmodule

// File: sv/page_frame_allocator_with_owner_tracking_core.sv
// one command in flight, ready only in idle; seed, failed allocate, rejected free go to done,
// allocate passes alloc, read passes read, an accepted free passes scan on the way to done;
// done holds until the result slot is free, and the next command is taken while the result shows;
// a free walks the tracking ram one entry per cycle, searching and shifting in one pass
// reset: synchronous active low clears stack top, tracked count and handshake state; rams not
// cleared, entries past the tracked count read as all ones; needs pfa_pkg, pfa_if, pfa_ram, pfa_apb_regs
module page_frame_allocator_with_owner_tracking_core
    import pfa_pkg::*;
#(
    parameter int TRACK_DEPTH = 16384,
    parameter int FREE_DEPTH  = 16384
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pfa_cmd_if.sink           i_cmd_if,
    pfa_res_if.source         o_res_if,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int FAW = $clog2(FREE_DEPTH);
    localparam int FCW = $clog2(FREE_DEPTH + 1);
    localparam int TAW = $clog2(TRACK_DEPTH);
    localparam int TCW = $clog2(TRACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    t_cfg w_cfg;

    logic [2:0]     r_state,     n_state;
    logic [FCW-1:0] r_free_top,  n_free_top;
    logic [TCW-1:0] r_total,     n_total;
    logic [15:0]    r_target,    n_target;
    logic [15:0]    r_owner,     n_owner;
    logic           r_hit,       n_hit;
    logic [TCW-1:0] r_ptr,       n_ptr;
    logic           r_pend,      n_pend;
    logic           r_found,     n_found;
    logic [TAW-1:0] r_chk_addr,  n_chk_addr;
    logic [TAW-1:0] r_prev_addr, n_prev_addr;
    logic [2:0]     r_res_status, n_res_status;
    logic [15:0]    r_res_frame,  n_res_frame;
    logic [15:0]    r_res_owner,  n_res_owner;
    logic           r_out_valid,  n_out_valid;
    logic [2:0]     r_out_status, n_out_status;
    logic [15:0]    r_out_frame,  n_out_frame;
    logic [15:0]    r_out_owner,  n_out_owner;
    logic [14:0]    r_out_count,  n_out_count;

    logic           w_in_acc;
    logic           w_in_range;
    logic           w_stack_full;
    logic [FCW-1:0] w_top_dec;
    logic [31:0]    w_idx_ext;
    logic           w_idx_hit;

    logic           w_stk_we;
    logic           w_stk_re;
    logic [FAW-1:0] w_stk_raddr;
    logic [15:0]    w_stk_rdata;

    logic           w_trk_we;
    logic [TAW-1:0] w_trk_waddr;
    logic [31:0]    w_trk_wdata;
    logic           w_trk_re;
    logic [TAW-1:0] w_trk_raddr;
    logic [31:0]    w_trk_rdata;

    pfa_apb_regs u_apb_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pfa_ram #(
        .DEPTH (FREE_DEPTH),
        .WIDTH (16)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (r_free_top[FAW-1:0]),
        .i_wdata (i_cmd_if.frame_number),
        .i_re    (w_stk_re),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rdata)
    );

    pfa_ram #(
        .DEPTH (TRACK_DEPTH),
        .WIDTH (32)
    ) u_track_ram (
        .i_clk   (i_clk),
        .i_we    (w_trk_we),
        .i_waddr (w_trk_waddr),
        .i_wdata (w_trk_wdata),
        .i_re    (w_trk_re),
        .i_raddr (w_trk_raddr),
        .o_rdata (w_trk_rdata)
    );

    assign i_cmd_if.ready = (r_state == S_IDLE);
    assign w_in_acc       = i_cmd_if.valid && (r_state == S_IDLE);
    assign w_in_range     = (i_cmd_if.frame_number >= w_cfg.low_frame) &&
                            ({1'b0, i_cmd_if.frame_number} < w_cfg.frame_limit);
    assign w_stack_full   = (r_free_top == FCW'(FREE_DEPTH));
    assign w_top_dec      = r_free_top - FCW'(1);
    assign w_stk_raddr    = w_top_dec[FAW-1:0];
    assign w_idx_ext      = 32'(i_cmd_if.entry_index);
    assign w_idx_hit      = (w_idx_ext < 32'(r_total));

    always_comb begin
        n_state      = r_state;
        n_free_top   = r_free_top;
        n_total      = r_total;
        n_target     = r_target;
        n_owner      = r_owner;
        n_hit        = r_hit;
        n_ptr        = r_ptr;
        n_pend       = r_pend;
        n_found      = r_found;
        n_chk_addr   = r_chk_addr;
        n_prev_addr  = r_prev_addr;
        n_res_status = r_res_status;
        n_res_frame  = r_res_frame;
        n_res_owner  = r_res_owner;
        n_out_valid  = r_out_valid && !o_res_if.ready;
        n_out_status = r_out_status;
        n_out_frame  = r_out_frame;
        n_out_owner  = r_out_owner;
        n_out_count  = r_out_count;
        w_stk_we     = 1'b0;
        w_stk_re     = 1'b0;
        w_trk_we     = 1'b0;
        w_trk_waddr  = r_prev_addr;
        w_trk_wdata  = w_trk_rdata;
        w_trk_re     = 1'b0;
        w_trk_raddr  = w_idx_ext[TAW-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_res_status = ST_OK;
                    n_res_frame  = 16'd0;
                    n_res_owner  = 16'd0;
                    n_target     = i_cmd_if.frame_number;
                    n_owner      = i_cmd_if.owner_id;
                    n_state      = S_DONE;
                    case (i_cmd_if.command)
                        CMD_SEED: begin
                            if (!w_in_range) begin
                                n_res_status = ST_RANGE;
                            end else if (w_stack_full) begin
                                n_res_status = ST_STACK;
                            end else begin
                                w_stk_we   = 1'b1;
                                n_free_top = r_free_top + FCW'(1);
                            end
                        end
                        CMD_ALLOC: begin
                            if (r_free_top == '0) begin
                                n_res_status = ST_STACK;
                            end else if (r_total == TCW'(TRACK_DEPTH)) begin
                                n_res_status = ST_TABLE;
                            end else begin
                                w_stk_re   = 1'b1;
                                n_free_top = w_top_dec;
                                n_state    = S_ALLOC;
                            end
                        end
                        CMD_FREE: begin
                            if (!w_in_range) begin
                                n_res_status = ST_RANGE;
                            end else if (w_stack_full) begin
                                n_res_status = ST_STACK;
                            end else begin
                                w_stk_we   = 1'b1;
                                n_free_top = r_free_top + FCW'(1);
                                n_ptr      = '0;
                                n_pend     = 1'b0;
                                n_found    = 1'b0;
                                n_state    = S_SCAN;
                            end
                        end
                        CMD_READ: begin
                            w_trk_re = w_idx_hit;
                            n_hit    = w_idx_hit;
                            n_state  = S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            S_ALLOC: begin
                w_trk_we    = 1'b1;
                w_trk_waddr = r_total[TAW-1:0];
                w_trk_wdata = {w_stk_rdata, r_owner};
                n_total     = r_total + TCW'(1);
                n_res_frame = w_stk_rdata;
                n_state     = S_DONE;
            end
            S_READ: begin
                n_res_frame = r_hit ? w_trk_rdata[31:16] : 16'hFFFF;
                n_res_owner = r_hit ? w_trk_rdata[15:0]  : 16'hFFFF;
                n_state     = S_DONE;
            end
            S_SCAN: begin
                if (r_pend) begin
                    if (r_found) begin
                        w_trk_we = 1'b1;
                    end else if (w_trk_rdata[31:16] == r_target) begin
                        n_found = 1'b1;
                    end
                    n_prev_addr = r_chk_addr;
                end
                if (r_ptr < r_total) begin
                    w_trk_re    = 1'b1;
                    w_trk_raddr = r_ptr[TAW-1:0];
                    n_chk_addr  = r_ptr[TAW-1:0];
                    n_ptr       = r_ptr + TCW'(1);
                    n_pend      = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        if (r_found) begin
                            n_total = r_total - TCW'(1);
                        end else begin
                            n_res_status = ST_UNTRACKED;
                        end
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res_if.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_frame  = r_res_frame;
                    n_out_owner  = r_res_owner;
                    n_out_count  = 15'(r_total);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_top  <= '0;
            r_total     <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_top  <= n_free_top;
            r_total     <= n_total;
            r_pend      <= n_pend;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target     <= n_target;
        r_owner      <= n_owner;
        r_hit        <= n_hit;
        r_ptr        <= n_ptr;
        r_chk_addr   <= n_chk_addr;
        r_prev_addr  <= n_prev_addr;
        r_res_status <= n_res_status;
        r_res_frame  <= n_res_frame;
        r_res_owner  <= n_res_owner;
        r_out_status <= n_out_status;
        r_out_frame  <= n_out_frame;
        r_out_owner  <= n_out_owner;
        r_out_count  <= n_out_count;
    end

    assign o_res_if.valid         = r_out_valid;
    assign o_res_if.status        = r_out_status;
    assign o_res_if.result_frame  = r_out_frame;
    assign o_res_if.result_owner  = r_out_owner;
    assign o_res_if.tracked_count = r_out_count;

    a_free_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_top <= FCW'(FREE_DEPTH))
        else $error("free stack top past depth");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TCW'(TRACK_DEPTH))
        else $error("tracked count past depth");

    a_scan_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ptr <= r_total))
        else $error("scan pointer past tracked count");

    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC) |=> (r_total == $past(r_total) + TCW'(1)))
        else $error("allocate did not grow tracked count");

    a_track_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_trk_we |-> (r_state == S_ALLOC || (r_state == S_SCAN && r_found)))
        else $error("tracking ram written outside allocate or shift");

endmodule
